// File: design/hashed_field_lookup_core_assert.svh
// Assertion macros for the hashed field lookup core.
`ifndef HASHED_FIELD_LOOKUP_CORE_ASSERT_SVH
`define HASHED_FIELD_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hfl_pkg.sv
// Shared types and constants of the hashed field lookup core.
package hfl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int HASH_W      = 25;
    localparam int OFFS_W      = 16;
    localparam int ENTRY_W     = HASH_W + OFFS_W;
    localparam logic [HASH_W:0] HASH_MODULUS = 26'd33554393;
    localparam int CHAR_SHIFT  = 8;

    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 40;

    localparam logic [1:0] CFG_ENTRY_COUNT   = 2'd0;
    localparam logic [1:0] CFG_DATA_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_RECORD_STRIDE = 2'd2;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_CHAR = 2'd1,
        FUNC_END  = 2'd2
    } hfl_func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } hfl_state_t;

endpackage

// File: design/hashed_field_lookup_core.sv
// Top level: running name hash, field table and sequential table search.
//
//  channel   | signals                            | beat
//  ----------+------------------------------------+---------------------------------
//  s_*       | s_tvalid s_tready s_tdata s_tuser  | one load, name byte or end item
//  m_*       | m_tvalid m_tready m_tdata          | one lookup result per end item
//  cfg_*     | cfg_we cfg_idx cfg_wdata           | one register write
//
// Load and name-byte beats are taken while idle; the input stays ready.
// An end beat starts a search that walks n entries (at most 64),
// with one table RAM read and one hash compare per cycle;
// input not ready meanwhile.
// A result waits in the output register; a new search may run behind it, then holds
// until that register frees, so output stalls stretch the end beat.
// Reset clears control, the name hash and the registers; the table is not cleared.
`include "hashed_field_lookup_core_assert.svh"

module hashed_field_lookup_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index[5:0], entry_hash[30:6], entry_offset[46:31], name_char[54:47],
    // record_index[70:55], zero pad
    input  logic [hfl_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]                     s_tuser,
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found[0], item_index[6:1], field_address[38:7], zero pad
    output logic [hfl_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_idx,
    input  logic [31:0]                    cfg_wdata
);

    // input fields
    logic [5:0]                   entry_index;
    logic [hfl_pkg::HASH_W-1:0]   entry_hash;
    logic [hfl_pkg::OFFS_W-1:0]   entry_offset;
    logic [7:0]                   name_char;
    logic [15:0]                  record_index;
    hfl_pkg::hfl_func_t           func;
    logic                         s_accept;

    assign entry_index  = s_tdata[5:0];
    assign entry_hash   = s_tdata[30:6];
    assign entry_offset = s_tdata[46:31];
    assign name_char    = s_tdata[54:47];
    assign record_index = s_tdata[70:55];
    assign func         = hfl_pkg::hfl_func_t'(s_tuser);

    // configuration registers
    logic [6:0]  entry_count_reg;
    logic [31:0] data_offset_reg;
    logic [15:0] record_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg   <= '0;
            data_offset_reg   <= '0;
            record_stride_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                hfl_pkg::CFG_ENTRY_COUNT:   entry_count_reg   <= cfg_wdata[6:0];
                hfl_pkg::CFG_DATA_OFFSET:   data_offset_reg   <= cfg_wdata;
                hfl_pkg::CFG_RECORD_STRIDE: record_stride_reg <= cfg_wdata[15:0];
                default:                    ;
            endcase
        end
    end

    // state
    hfl_pkg::hfl_state_t          state_reg, state_next;
    logic [hfl_pkg::HASH_W-1:0]   name_hash_reg, name_hash_next;
    logic [hfl_pkg::HASH_W-1:0]   key_reg;
    logic [hfl_pkg::CNT_W-1:0]    limit_reg;
    logic [hfl_pkg::CNT_W-1:0]    issue_ptr_reg, issue_ptr_next;
    logic                         pend_vld_reg, pend_vld_next;
    logic [hfl_pkg::IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [31:0]                  prod_reg;
    logic [31:0]                  base_reg;
    logic                         res_found_reg;
    logic [5:0]                   res_idx_reg;
    logic [31:0]                  res_addr_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [hfl_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // table RAM: {offset, hash}
    logic                          ram_we;
    logic [hfl_pkg::IDX_W-1:0]     ram_waddr;
    logic [hfl_pkg::ENTRY_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [hfl_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [hfl_pkg::HASH_W-1:0]    rd_hash;
    logic [hfl_pkg::OFFS_W-1:0]    rd_offset;

    // datapath helpers
    logic [hfl_pkg::HASH_W:0]      hash_sum;
    logic [hfl_pkg::CNT_W-1:0]     limit_calc;
    logic                          hit;
    logic                          miss;
    logic                          load_out;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == hfl_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign rd_hash   = ram_rdata[hfl_pkg::HASH_W-1:0];
    assign rd_offset = ram_rdata[hfl_pkg::ENTRY_W-1:hfl_pkg::HASH_W];

    assign ram_we    = s_accept && (func == hfl_pkg::FUNC_LOAD)
                       && (32'(entry_index) < 32'(hfl_pkg::TABLE_DEPTH));
    assign ram_waddr = hfl_pkg::IDX_W'(entry_index);
    assign ram_wdata = {entry_offset, entry_hash};

    // sum stays below twice the modulus: one conditional subtract
    assign hash_sum  = {1'b0, name_hash_reg}
                       + {{(hfl_pkg::HASH_W + 1 - 8 - hfl_pkg::CHAR_SHIFT){1'b0}},
                          name_char, {hfl_pkg::CHAR_SHIFT{1'b0}}};

    assign limit_calc = (32'(entry_count_reg) > 32'(hfl_pkg::TABLE_DEPTH))
                        ? hfl_pkg::CNT_W'(hfl_pkg::TABLE_DEPTH)
                        : hfl_pkg::CNT_W'(entry_count_reg);

    assign hit      = (state_reg == hfl_pkg::ST_SCAN) && pend_vld_reg && (rd_hash == key_reg);
    assign miss     = (state_reg == hfl_pkg::ST_SCAN) && !pend_vld_reg
                      && (issue_ptr_reg >= limit_reg);
    assign load_out = (state_reg == hfl_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    hfl_ram #(
        .WIDTH (hfl_pkg::ENTRY_W),
        .DEPTH (hfl_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_ptr_reg[hfl_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        name_hash_next = name_hash_reg;
        issue_ptr_next = issue_ptr_reg;
        pend_vld_next  = 1'b0;
        pend_idx_next  = pend_idx_reg;
        ram_re         = 1'b0;
        m_tvalid_next  = m_tvalid_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            hfl_pkg::ST_IDLE:
            begin
                if (s_accept && (func == hfl_pkg::FUNC_CHAR))
                begin
                    name_hash_next = (hash_sum >= hfl_pkg::HASH_MODULUS)
                                     ? hfl_pkg::HASH_W'(hash_sum - hfl_pkg::HASH_MODULUS)
                                     : hash_sum[hfl_pkg::HASH_W-1:0];
                end
                else if (s_accept && (func == hfl_pkg::FUNC_END))
                begin
                    name_hash_next = '0;
                    issue_ptr_next = '0;
                    state_next     = hfl_pkg::ST_SCAN;
                end
            end
            hfl_pkg::ST_SCAN:
            begin
                if (hit || miss)
                begin
                    state_next = hfl_pkg::ST_DONE;
                end
                else if (issue_ptr_reg < limit_reg)
                begin
                    // read entry issue_ptr; compared next cycle
                    ram_re         = 1'b1;
                    pend_vld_next  = 1'b1;
                    pend_idx_next  = issue_ptr_reg[hfl_pkg::IDX_W-1:0];
                    issue_ptr_next = issue_ptr_reg + hfl_pkg::CNT_W'(1);
                end
            end
            hfl_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = hfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hfl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hfl_pkg::ST_IDLE;
            name_hash_reg <= '0;
            issue_ptr_reg <= '0;
            pend_vld_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            name_hash_reg <= name_hash_next;
            issue_ptr_reg <= issue_ptr_next;
            pend_vld_reg  <= pend_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        if (s_accept && (func == hfl_pkg::FUNC_END))
        begin
            key_reg   <= name_hash_reg;
            limit_reg <= limit_calc;
            prod_reg  <= 32'(record_index) * 32'(record_stride_reg);
        end
        // base is ready by the first compare, in the cycle after the first read
        if (state_reg == hfl_pkg::ST_SCAN)
        begin
            base_reg <= data_offset_reg + prod_reg;
        end
        if (hit)
        begin
            res_found_reg <= 1'b1;
            res_idx_reg   <= 6'(pend_idx_reg);
            res_addr_reg  <= base_reg + 32'(rd_offset);
        end
        else if (miss)
        begin
            res_found_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_addr_reg  <= '0;
        end
        if (load_out)
        begin
            m_tdata_reg <= {1'b0, res_addr_reg, res_idx_reg, res_found_reg};
        end
    end

    `HFL_ASSERT_NOW(a_hash_range, 1'b1,
        name_hash_reg < hfl_pkg::HASH_W'(hfl_pkg::HASH_MODULUS), "name hash left modulus range")
    `HFL_ASSERT_NEXT(a_hash_clear, s_accept && (func == hfl_pkg::FUNC_END),
        name_hash_reg == '0, "name hash not cleared by end beat")
    `HFL_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tdata[0],
        m_tdata[38:1] == '0, "miss result carries nonzero fields")
    `HFL_ASSERT_NOW(a_pend_limit, pend_vld_reg,
        hfl_pkg::CNT_W'(pend_idx_reg) < limit_reg, "table read beyond search limit")

endmodule

// File: design/hfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
